FILE: rtl/tvp_pkg.sv
package tvp_pkg;

  localparam int unsigned TICKS_PER_SECOND = 1000;
  localparam int unsigned GAIN_FRAC_BITS   = 8;

  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned ERR_W      = 18;
  localparam int unsigned SUM_W      = 40;
  localparam int unsigned SUM_SPLIT  = 20;
  localparam int unsigned MUL_A_W    = 36;
  localparam int unsigned MUL_B_W    = 18;
  localparam int unsigned PROD_W     = MUL_A_W + MUL_B_W;
  localparam int unsigned DIV_NUM_W  = 58;
  localparam int unsigned DIV_DEN_W  = 34;
  localparam int unsigned QUO_W      = 18;
  localparam int unsigned QUO_CNT_W  = $clog2(QUO_W);

  // reciprocal of the tick rate for divisions by a constant
  localparam int unsigned RECIP_SH = 38;
  localparam int unsigned RECIP_W  = 29;
  localparam longint unsigned RECIP_L =
    ((64'd1 << RECIP_SH) + TICKS_PER_SECOND - 1) / TICKS_PER_SECOND;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
  localparam int unsigned VEL_W    = 32 + RECIP_W - RECIP_SH;
  localparam int unsigned OMAG_W   = DIV_NUM_W - GAIN_FRAC_BITS;
  localparam int unsigned OQ_W     = $clog2(32768 * TICKS_PER_SECOND);
  localparam int unsigned OQ_P_W   = OQ_W + RECIP_W;
  localparam int unsigned OQUO_W   = OQ_P_W - RECIP_SH;
  localparam logic [OMAG_W-1:0] DRIVE_LIM = OMAG_W'(64'd32768 * TICKS_PER_SECOND);

  localparam logic [GAIN_W-1:0] GAIN_P_RST = 16'd1075;
  localparam logic [GAIN_W-1:0] GAIN_I_RST = 16'd2560;
  localparam logic [GAIN_W-1:0] GAIN_D_RST = 16'd0;

  localparam logic [1:0] REG_GAIN_P = 2'd0;
  localparam logic [1:0] REG_GAIN_I = 2'd1;
  localparam logic [1:0] REG_GAIN_D = 2'd2;

  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic signed [MUL_B_W-1:0] TPS_MUL = MUL_B_W'(TICKS_PER_SECOND);

  localparam logic signed [ERR_W-1:0] ERR_MAX = {1'b0, {(ERR_W-1){1'b1}}};
  localparam logic signed [ERR_W-1:0] ERR_MIN = {1'b1, {(ERR_W-1){1'b0}}};
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef enum logic [1:0] {
    DIR_ZERO = 2'b00,
    DIR_POS  = 2'b01,
    DIR_NEG  = 2'b11
  } dir_e;

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD,
    S_PLAN, S_ACCN, S_DECN, S_AD, S_VM2, S_VS2, S_VE2, S_SUMC, S_CTPS, S_DEN,
    S_GOA, S_WA, S_GOD, S_WD, S_GOC, S_WC,
    S_RAMP, S_GOV, S_WV, S_ERR, S_SUM, S_MD, S_MADD, S_MHI, S_MT, S_MFIN,
    S_GOO, S_WO, S_OUT
  } state_e;

  typedef enum logic [4:0] {
    DP_NONE,
    DP_PLAN, DP_ACCN, DP_DECN, DP_AD, DP_VM2, DP_VS2, DP_VE2, DP_SUMC, DP_CTPS,
    DP_DEN, DP_GOA, DP_WA, DP_GOD, DP_WD, DP_GOC, DP_WC,
    DP_RAMP, DP_GOV, DP_WV, DP_ERR, DP_SUM, DP_MD, DP_MADD, DP_MHI, DP_MT,
    DP_MFIN, DP_GOO, DP_WO, DP_OUT
  } dp_step_e;

  typedef struct packed {
    dp_step_e step;
    logic     load;
  } cmd_t;

  typedef struct packed {
    logic item_tick;
    logic div_busy;
    logic div_done;
  } status_t;

  typedef struct packed {
    logic [GAIN_W-1:0] p;
    logic [GAIN_W-1:0] i;
    logic [GAIN_W-1:0] d;
  } gains_t;

  typedef struct packed {
    logic               operation;
    logic signed [15:0] distance;
    logic [14:0]        start_speed;
    logic [14:0]        end_speed;
    logic [15:0]        peak_speed;
    logic [15:0]        acceleration;
    logic signed [15:0] measured_speed;
    logic signed [15:0] target_offset;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] drive;
    logic               motion_done;
  } out_item_t;

endpackage

FILE: rtl/tvp_if.sv
interface tvp_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic signed [15:0] distance;
  logic [14:0]        start_speed;
  logic [14:0]        end_speed;
  logic [15:0]        peak_speed;
  logic [15:0]        acceleration;
  logic signed [15:0] measured_speed;
  logic signed [15:0] target_offset;

  modport source (
    output valid, operation, distance, start_speed, end_speed, peak_speed,
           acceleration, measured_speed, target_offset,
    input  ready
  );
  modport sink (
    input  valid, operation, distance, start_speed, end_speed, peak_speed,
           acceleration, measured_speed, target_offset,
    output ready
  );
endinterface

interface tvp_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] drive;
  logic               motion_done;

  modport source (output valid, drive, motion_done, input ready);
  modport sink (input valid, drive, motion_done, output ready);
endinterface

FILE: rtl/trapezoid_velocity_pi_loop.sv
// trapezoidal velocity profile with a PID velocity loop
// input channel in_i carries start items (operation 0) and 1 ms ticks (operation 1);
// output channel out_o carries one drive/motion_done result per tick and
// nothing for a start item. gains are written over the APB port: gain_p at 0x0,
// gain_i at 0x4, gain_d at 0x8 (paddr[1:0] unused); writes to 0xC-0xF are ignored.
// one item is processed at a time. a start item's time in the block is dominated
// by three divisions in the radix-2 divider at 18 quotient bits, one bit a
// cycle. a division whose quotient saturates or whose divisor is zero finishes
// without iterating, which shortens a start item.
// a tick's result becomes valid as the block returns to idle and can take the
// next item; the scaling by the tick rate uses reciprocal multiplication, plus
// a 36x18 multiplier used once per step.
// in ready is high only while the block is idle. the result sits in an output
// register; if the receiver stalls the next item is still taken and worked on,
// and the block waits only when a new result is ready while the old one is
// still held.
// reset restores the gain defaults and clears the profile, integral and done
// state; no result is pending after reset.
module trapezoid_velocity_pi_loop (
  input  logic        clk_i,
  input  logic        rst_ni,
  tvp_in_if.sink      in_i,
  tvp_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tvp_pkg::*;

  gains_t    gains;
  cmd_t      cmd;
  status_t   status;
  in_item_t  item;
  out_item_t result;

  assign item = '{operation: in_i.operation, distance: in_i.distance,
                  start_speed: in_i.start_speed, end_speed: in_i.end_speed,
                  peak_speed: in_i.peak_speed, acceleration: in_i.acceleration,
                  measured_speed: in_i.measured_speed,
                  target_offset: in_i.target_offset};

  tvp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .gains_o (gains)
  );

  tvp_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .gains_i  (gains),
    .item_i   (item),
    .status_o (status),
    .result_o (result)
  );

  tvp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  assign out_o.drive       = result.drive;
  assign out_o.motion_done = result.motion_done;
endmodule

FILE: rtl/tvp_cfg.sv
module tvp_cfg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [3:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready,
  output tvp_pkg::gains_t gains_o
);
  import tvp_pkg::*;

  logic [GAIN_W-1:0] gain_p_q, gain_i_q, gain_d_q;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q <= GAIN_P_RST;
      gain_i_q <= GAIN_I_RST;
      gain_d_q <= GAIN_D_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_GAIN_P: gain_p_q <= pwdata[GAIN_W-1:0];
        REG_GAIN_I: gain_i_q <= pwdata[GAIN_W-1:0];
        REG_GAIN_D: gain_d_q <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_GAIN_P: prdata = 32'(gain_p_q);
      REG_GAIN_I: prdata = 32'(gain_i_q);
      REG_GAIN_D: prdata = 32'(gain_d_q);
      default:    prdata = '0;
    endcase
  end

  assign gains_o = '{p: gain_p_q, i: gain_i_q, d: gain_d_q};
endmodule

FILE: rtl/tvp_div.sv
module tvp_div (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic signed [tvp_pkg::DIV_NUM_W-1:0]   num_i,
  input  logic [tvp_pkg::DIV_DEN_W-1:0]          den_i,
  output logic                                   busy_o,
  output logic                                   done_o,
  output logic [tvp_pkg::QUO_W-1:0]              quo_o,
  output logic                                   neg_o
);
  import tvp_pkg::*;

  logic                   busy_q, done_q;
  logic [QUO_CNT_W-1:0]   cnt_q;
  logic [DIV_NUM_W-1:0]   rem_q, dsh_q;
  logic [QUO_W-1:0]       quo_q;
  logic                   neg_q;
  logic [DIV_NUM_W-1:0]   mag, den_ext, den_top;
  logic                   over, ge;

  assign mag     = num_i[DIV_NUM_W-1] ? DIV_NUM_W'(-num_i) : DIV_NUM_W'(num_i);
  assign den_ext = DIV_NUM_W'(den_i);
  assign den_top = den_ext << QUO_W;
  assign over    = (den_i == '0) || (mag >= den_top);
  assign ge      = rem_q >= dsh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= !over;
        done_q <= over;
        cnt_q  <= QUO_CNT_W'(QUO_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= mag;
      dsh_q <= den_ext << (QUO_W - 1);
      quo_q <= over ? '1 : '0;
      neg_q <= num_i[DIV_NUM_W-1] && (den_i != '0);
    end else if (busy_q) begin
      rem_q <= ge ? rem_q - dsh_q : rem_q;
      dsh_q <= dsh_q >> 1;
      quo_q <= {quo_q[QUO_W-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign neg_o  = neg_q;
endmodule

FILE: rtl/tvp_dp.sv
module tvp_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tvp_pkg::cmd_t      cmd_i,
  input  tvp_pkg::gains_t    gains_i,
  input  tvp_pkg::in_item_t  item_i,
  output tvp_pkg::status_t   status_o,
  output tvp_pkg::out_item_t result_o
);
  import tvp_pkg::*;

  in_item_t item_q;
  dir_e     dir_q;
  logic [16:0] dist_q;
  logic [15:0] ae_q, vme_q;

  logic [31:0] speed_q;
  logic [15:0] step_q, acc_t_q, cru_t_q, dec_t_q;
  logic signed [SUM_W-1:0] sum_q;
  logic signed [ERR_W-1:0] last_q, err_q;
  logic done_q;

  logic signed [PROD_W-1:0]    prod_q, prod_d, numa_q, numd_q, numc_q;
  logic signed [MUL_A_W-1:0]   acc_q, mul_a;
  logic signed [MUL_B_W-1:0]   mul_b;
  logic signed [DIV_NUM_W-1:0] num_q, div_num;
  logic [DIV_DEN_W-1:0]        denc_q, div_den;
  logic [QUO_W-1:0]            vel_q, div_quo;
  logic                        div_start, div_busy, div_done, div_neg;
  logic signed [15:0]          drive_q;
  logic                        odone_q;

  logic [32+RECIP_W-1:0]       vprod_q;
  logic [VEL_W-1:0]            vel_full;
  logic [DIV_NUM_W-1:0]        num_mag;
  logic [OMAG_W-1:0]           omag_q;
  logic                        oneg_q, osat_q;
  logic [OQ_P_W-1:0]           oprod_q;
  logic [OQUO_W-1:0]           oquo;

  logic signed [MUL_A_W-1:0] vs_a, ve_a, vme_a, dist_a;
  logic signed [MUL_B_W-1:0] vs_b, ve_b, vme_b, ae_b, gp_b, gi_b, gd_b;
  logic signed [ERR_W:0]     de;
  logic [15:0]               ticks_res;
  logic signed [ERR_W+2:0]   tgt, err_full;
  logic signed [ERR_W-1:0]   err_sat;
  logic signed [SUM_W:0]     sum_ext;
  logic signed [SUM_W-1:0]   sum_sat;
  logic [32:0]               speed_up;
  logic signed [15:0]        drive_res;

  assign vs_a   = MUL_A_W'(item_q.start_speed);
  assign ve_a   = MUL_A_W'(item_q.end_speed);
  assign vme_a  = MUL_A_W'(vme_q);
  assign dist_a = MUL_A_W'(dist_q);
  assign vs_b   = MUL_B_W'(item_q.start_speed);
  assign ve_b   = MUL_B_W'(item_q.end_speed);
  assign vme_b  = MUL_B_W'(vme_q);
  assign ae_b   = MUL_B_W'(ae_q);
  assign gp_b   = MUL_B_W'(gains_i.p);
  assign gi_b   = MUL_B_W'(gains_i.i);
  assign gd_b   = MUL_B_W'(gains_i.d);
  assign de     = {err_q[ERR_W-1], err_q} - {last_q[ERR_W-1], last_q};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.step)
      DP_PLAN: begin mul_a = vs_a; mul_b = TPS_MUL; end
      DP_ACCN: begin mul_a = vme_a - vs_a; mul_b = TPS_MUL; end
      DP_DECN: begin mul_a = vme_a - ve_a; mul_b = TPS_MUL; end
      DP_AD:   begin mul_a = dist_a; mul_b = ae_b; end
      DP_VM2:  begin mul_a = vme_a; mul_b = vme_b; end
      DP_VS2:  begin mul_a = vs_a; mul_b = vs_b; end
      DP_VE2:  begin mul_a = ve_a; mul_b = ve_b; end
      DP_CTPS: begin mul_a = acc_q; mul_b = TPS_MUL; end
      DP_DEN:  begin mul_a = vme_a; mul_b = ae_b; end
      DP_SUM:  begin mul_a = MUL_A_W'(err_q); mul_b = gp_b; end
      DP_MD:   begin mul_a = MUL_A_W'(de); mul_b = gd_b; end
      DP_MADD: begin mul_a = MUL_A_W'(sum_q[SUM_SPLIT-1:0]); mul_b = gi_b; end
      DP_MHI:  begin mul_a = acc_q; mul_b = TPS_MUL; end
      DP_MT: begin
        mul_a = MUL_A_W'(signed'(sum_q[SUM_W-1:SUM_SPLIT]));
        mul_b = gi_b;
      end
      default: ;
    endcase
  end

  assign prod_d = mul_a * mul_b;

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (cmd_i.step)
      DP_GOA: begin div_start = 1'b1; div_num = DIV_NUM_W'(numa_q);
        div_den = DIV_DEN_W'(ae_q); end
      DP_GOD: begin div_start = 1'b1; div_num = DIV_NUM_W'(numd_q);
        div_den = DIV_DEN_W'(ae_q); end
      DP_GOC: begin div_start = 1'b1; div_num = DIV_NUM_W'(numc_q);
        div_den = denc_q; end
      default: ;
    endcase
  end

  tvp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .neg_o   (div_neg)
  );

  assign ticks_res = div_neg ? 16'd0 :
                     (div_quo > QUO_W'(16'hFFFF)) ? 16'hFFFF : div_quo[15:0];

  // velocity and drive scaling by reciprocal multiplication
  assign vel_full = vprod_q[32+RECIP_W-1:RECIP_SH];
  assign num_mag  = num_q[DIV_NUM_W-1] ? DIV_NUM_W'(-num_q) : DIV_NUM_W'(num_q);
  assign oquo     = oprod_q[OQ_P_W-1:RECIP_SH];

  always_comb begin
    case (dir_q)
      DIR_POS: tgt = (ERR_W+3)'(vel_q);
      DIR_NEG: tgt = -(ERR_W+3)'(vel_q);
      default: tgt = '0;
    endcase
    tgt      = tgt + (ERR_W+3)'(item_q.target_offset);
    err_full = tgt - (ERR_W+3)'(item_q.measured_speed);
    if (err_full > (ERR_W+3)'(ERR_MAX)) begin
      err_sat = ERR_MAX;
    end else if (err_full < (ERR_W+3)'(ERR_MIN)) begin
      err_sat = ERR_MIN;
    end else begin
      err_sat = err_full[ERR_W-1:0];
    end
  end

  assign sum_ext = (SUM_W+1)'(sum_q) + (SUM_W+1)'(err_q);
  assign sum_sat = (sum_ext[SUM_W] != sum_ext[SUM_W-1]) ?
                   (sum_ext[SUM_W] ? SUM_MIN : SUM_MAX) : sum_ext[SUM_W-1:0];
  assign speed_up = 33'(speed_q) + 33'(step_q);

  always_comb begin
    if (oneg_q) begin
      drive_res = osat_q ? -16'sd32768 : -signed'(16'(oquo));
    end else begin
      drive_res = osat_q ? 16'sd32767 : signed'(16'(oquo));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q <= '0;
      step_q  <= '0;
      dir_q   <= DIR_ZERO;
      acc_t_q <= '0;
      cru_t_q <= '0;
      dec_t_q <= '0;
      sum_q   <= '0;
      last_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      case (cmd_i.step)
        DP_PLAN: begin
          if (item_q.distance < 0) begin
            dir_q <= DIR_NEG;
          end else if (item_q.distance == 0) begin
            dir_q <= DIR_ZERO;
          end else begin
            dir_q <= DIR_POS;
          end
          step_q <= (item_q.distance == 0) ? 16'd1 : item_q.acceleration;
          last_q <= '0;
          done_q <= 1'b0;
        end
        DP_ACCN: speed_q <= prod_q[31:0];
        DP_WA: if (div_done) acc_t_q <= ticks_res;
        DP_WD: if (div_done) dec_t_q <= ticks_res;
        DP_WC: if (div_done) cru_t_q <= ticks_res;
        DP_RAMP: begin
          if (dir_q != DIR_ZERO) begin
            if (acc_t_q != '0) begin
              speed_q <= speed_up[32] ? '1 : speed_up[31:0];
              acc_t_q <= acc_t_q - 1'b1;
            end else if (cru_t_q != '0) begin
              cru_t_q <= cru_t_q - 1'b1;
            end else if (dec_t_q != '0) begin
              speed_q <= (speed_q > 32'(step_q)) ? speed_q - 32'(step_q) : '0;
              dec_t_q <= dec_t_q - 1'b1;
            end else begin
              done_q <= 1'b1;
            end
          end
        end
        DP_SUM: sum_q <= sum_sat;
        DP_OUT: last_q <= err_q;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (cmd_i.load) begin
      item_q <= item_i;
    end
    case (cmd_i.step)
      DP_PLAN: begin
        dist_q <= (item_q.distance < 0) ? 17'(-(17'(item_q.distance)))
                                        : 17'(item_q.distance);
        ae_q   <= (item_q.distance == 0) ? 16'd1 : item_q.acceleration;
        vme_q  <= (item_q.distance == 0) ? 16'd1 : item_q.peak_speed;
      end
      DP_DECN: numa_q <= prod_q;
      DP_AD:   numd_q <= prod_q;
      DP_VM2:  acc_q  <= MUL_A_W'(prod_q) <<< 1;
      DP_VS2:  acc_q  <= acc_q - (MUL_A_W'(prod_q) <<< 1);
      DP_VE2:  acc_q  <= acc_q + MUL_A_W'(prod_q);
      DP_SUMC: acc_q  <= acc_q + MUL_A_W'(prod_q);
      DP_DEN:  numc_q <= prod_q;
      DP_GOA:  denc_q <= DIV_DEN_W'(prod_q) << 1;
      DP_GOV:  vprod_q <= speed_q * RECIP;
      DP_WV:   vel_q  <= (|vel_full[VEL_W-1:QUO_W]) ? '1 : vel_full[QUO_W-1:0];
      DP_ERR:  err_q  <= err_sat;
      DP_MD:   acc_q  <= MUL_A_W'(prod_q);
      DP_MADD: acc_q  <= acc_q + MUL_A_W'(prod_q);
      DP_MHI:  num_q  <= DIV_NUM_W'(prod_q);
      DP_MT:   num_q  <= num_q + DIV_NUM_W'(prod_q);
      DP_MFIN: num_q  <= num_q + (DIV_NUM_W'(prod_q) <<< SUM_SPLIT);
      DP_GOO: begin
        omag_q <= num_mag[DIV_NUM_W-1:GAIN_FRAC_BITS];
        oneg_q <= num_q[DIV_NUM_W-1];
      end
      DP_WO: begin
        osat_q  <= (omag_q >= DRIVE_LIM);
        oprod_q <= omag_q[OQ_W-1:0] * RECIP;
      end
      DP_OUT: begin
        drive_q <= drive_res;
        odone_q <= done_q;
      end
      default: ;
    endcase
  end

  assign status_o = '{item_tick: (item_q.operation == OP_TICK),
                      div_busy: div_busy, div_done: div_done};
  assign result_o = '{drive: drive_q, motion_done: odone_q};
endmodule

FILE: rtl/tvp_ctrl.sv
module tvp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  tvp_pkg::status_t status_i,
  output tvp_pkg::cmd_t    cmd_o
);
  import tvp_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_free, in_xfer;

  assign out_free = !out_valid_q || out_ready_i;
  assign in_xfer  = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_LOAD;
      S_LOAD: state_d = status_i.item_tick ? S_RAMP : S_PLAN;
      S_PLAN: state_d = S_ACCN;
      S_ACCN: state_d = S_DECN;
      S_DECN: state_d = S_AD;
      S_AD:   state_d = S_VM2;
      S_VM2:  state_d = S_VS2;
      S_VS2:  state_d = S_VE2;
      S_VE2:  state_d = S_SUMC;
      S_SUMC: state_d = S_CTPS;
      S_CTPS: state_d = S_DEN;
      S_DEN:  state_d = S_GOA;
      S_GOA:  state_d = S_WA;
      S_WA:   if (status_i.div_done) state_d = S_GOD;
      S_GOD:  state_d = S_WD;
      S_WD:   if (status_i.div_done) state_d = S_GOC;
      S_GOC:  state_d = S_WC;
      S_WC:   if (status_i.div_done) state_d = S_IDLE;
      S_RAMP: state_d = S_GOV;
      S_GOV:  state_d = S_WV;
      S_WV:   state_d = S_ERR;
      S_ERR:  state_d = S_SUM;
      S_SUM:  state_d = S_MD;
      S_MD:   state_d = S_MADD;
      S_MADD: state_d = S_MHI;
      S_MHI:  state_d = S_MT;
      S_MT:   state_d = S_MFIN;
      S_MFIN: state_d = S_GOO;
      S_GOO:  state_d = S_WO;
      S_WO:   state_d = S_OUT;
      S_OUT:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.load = in_xfer;
    case (state_q)
      S_PLAN: cmd_o.step = DP_PLAN;
      S_ACCN: cmd_o.step = DP_ACCN;
      S_DECN: cmd_o.step = DP_DECN;
      S_AD:   cmd_o.step = DP_AD;
      S_VM2:  cmd_o.step = DP_VM2;
      S_VS2:  cmd_o.step = DP_VS2;
      S_VE2:  cmd_o.step = DP_VE2;
      S_SUMC: cmd_o.step = DP_SUMC;
      S_CTPS: cmd_o.step = DP_CTPS;
      S_DEN:  cmd_o.step = DP_DEN;
      S_GOA:  cmd_o.step = DP_GOA;
      S_WA:   cmd_o.step = DP_WA;
      S_GOD:  cmd_o.step = DP_GOD;
      S_WD:   cmd_o.step = DP_WD;
      S_GOC:  cmd_o.step = DP_GOC;
      S_WC:   cmd_o.step = DP_WC;
      S_RAMP: cmd_o.step = DP_RAMP;
      S_GOV:  cmd_o.step = DP_GOV;
      S_WV:   cmd_o.step = DP_WV;
      S_ERR:  cmd_o.step = DP_ERR;
      S_SUM:  cmd_o.step = DP_SUM;
      S_MD:   cmd_o.step = DP_MD;
      S_MADD: cmd_o.step = DP_MADD;
      S_MHI:  cmd_o.step = DP_MHI;
      S_MT:   cmd_o.step = DP_MT;
      S_MFIN: cmd_o.step = DP_MFIN;
      S_GOO:  cmd_o.step = DP_GOO;
      S_WO:   cmd_o.step = DP_WO;
      S_OUT:  cmd_o.step = out_free ? DP_OUT : DP_NONE;
      default: cmd_o.step = DP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_GOA || state_q == S_GOD || state_q == S_GOC) |-> !status_i.div_busy)
    else $error("divider started while busy");

  a_div_done_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.div_done |-> (state_q == S_WA || state_q == S_WD || state_q == S_WC))
    else $error("divider finished outside a wait state");

  a_out_from_out_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT))
    else $error("result raised outside output state");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == S_LOAD))
    else $error("accepted item not loaded");
endmodule

FILE: tb/tb_top.sv
module tb_top;
  import tvp_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned SETTLE_CYCLES  = 150;
  localparam longint SUM_HI = 64'sd549755813887;
  localparam longint SUM_LO = -64'sd549755813888;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  tvp_in_if  in_bus ();
  tvp_out_if out_bus ();

  trapezoid_velocity_pi_loop dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor state
  logic [15:0] kp, ki, kd;
  longint      speed_milli;
  longint      ramp_step;
  longint      heading;
  longint      accel_left, cruise_left, decel_left;
  longint      err_sum, prev_err;
  bit          done_flag;

  in_item_t    pending_items[$];
  out_item_t   expected_drive[$];
  bit          hold_items;
  int unsigned send_gap;
  int unsigned stall_left;
  int unsigned quiet_cycles;
  int unsigned fails;
  int unsigned n_start, n_tick, n_done, n_settings;

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint phase_len(longint num, longint den);
    longint q;
    if (den == 0) return 65535;
    q = num / den;
    return clip(q, 0, 65535);
  endfunction

  task automatic plan_profile(input in_item_t it);
    longint d, vs, ve, vm, a, travel;
    d  = longint'(it.distance);
    vs = longint'(it.start_speed);
    ve = longint'(it.end_speed);
    vm = longint'(it.peak_speed);
    a  = longint'(it.acceleration);
    if (d < 0) begin
      heading = -1;
      travel = -d;
    end else if (d == 0) begin
      heading = 0;
      travel = 0;
      a = 1;
      vm = 1;
    end else begin
      heading = 1;
      travel = d;
    end
    speed_milli = vs * TICKS_PER_SECOND;
    ramp_step = a;
    if (a == 0) begin
      accel_left = 65535;
      cruise_left = 65535;
      decel_left = 65535;
    end else begin
      accel_left = phase_len((vm - vs) * TICKS_PER_SECOND, a);
      decel_left = phase_len((vm - ve) * TICKS_PER_SECOND, a);
      cruise_left = phase_len((2 * a * travel - 2 * vm * vm + vs * vs + ve * ve)
                              * TICKS_PER_SECOND, 2 * a * vm);
    end
    prev_err = 0;
    done_flag = 0;
  endtask

  function automatic out_item_t control_tick(input in_item_t it);
    out_item_t r;
    longint target, e, num, q;
    if (heading != 0) begin
      if (accel_left > 0) begin
        speed_milli = clip(speed_milli + ramp_step, 0, 64'hFFFF_FFFF);
        accel_left--;
      end else if (cruise_left > 0) begin
        cruise_left--;
      end else if (decel_left > 0) begin
        speed_milli = clip(speed_milli - ramp_step, 0, 64'hFFFF_FFFF);
        decel_left--;
      end else begin
        done_flag = 1;
      end
    end
    target = heading * (speed_milli / TICKS_PER_SECOND) + longint'(it.target_offset);
    e = clip(target - longint'(it.measured_speed), -131072, 131071);
    err_sum = clip(err_sum + e, SUM_LO, SUM_HI);
    num = longint'(kp) * e * TICKS_PER_SECOND
        + longint'(kd) * (e - prev_err) * TICKS_PER_SECOND
        + longint'(ki) * err_sum;
    prev_err = e;
    q = clip(num / (longint'(TICKS_PER_SECOND) << GAIN_FRAC_BITS), -32768, 32767);
    r.drive = q[15:0];
    r.motion_done = done_flag;
    return r;
  endfunction

  function automatic in_item_t mk_start(longint d, longint vs, longint ve, longint vm,
                                        longint a);
    in_item_t it;
    it.operation = OP_START;
    it.distance = d[15:0];
    it.start_speed = vs[14:0];
    it.end_speed = ve[14:0];
    it.peak_speed = vm[15:0];
    it.acceleration = a[15:0];
    it.measured_speed = 16'($urandom);
    it.target_offset = 16'($urandom);
    return it;
  endfunction

  function automatic in_item_t mk_tick(longint meas, longint ofs);
    in_item_t it;
    it = in_item_t'($bits(in_item_t)'({$urandom, $urandom, $urandom, $urandom}));
    it.operation = OP_TICK;
    it.measured_speed = meas[15:0];
    it.target_offset = ofs[15:0];
    return it;
  endfunction

  function automatic in_item_t random_tick();
    if ($urandom_range(0, 9) == 0)
      return mk_tick($urandom, $urandom);
    return mk_tick(longint'($urandom_range(0, 6000)) - 3000,
                   longint'($urandom_range(0, 200)) - 100);
  endfunction

  function automatic in_item_t random_start();
    longint vs, vm;
    if ($urandom_range(0, 3) == 0)
      return in_item_t'({1'b0, 16'($urandom), 15'($urandom), 15'($urandom),
                         16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)});
    vs = $urandom_range(0, 500);
    vm = vs + $urandom_range(0, 3000);
    return mk_start(($urandom_range(0, 1) ? 1 : -1) * longint'($urandom_range(1, 2000)),
                    vs, $urandom_range(0, 500), vm, $urandom_range(20000, 65535));
  endfunction

  task automatic apb_write(input logic [3:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    case (addr)
      4'(REG_GAIN_P * 4): kp = data[15:0];
      4'(REG_GAIN_I * 4): ki = data[15:0];
      4'(REG_GAIN_D * 4): kd = data[15:0];
      default: ;
    endcase
  endtask

  task automatic set_gains(input logic [31:0] p, input logic [31:0] i,
                           input logic [31:0] d);
    apb_write(4'(REG_GAIN_P * 4), p);
    apb_write(4'(REG_GAIN_I * 4), i);
    apb_write(4'(REG_GAIN_D * 4), d);
    apb_write(4'd12, $urandom);
    n_settings++;
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || in_bus.valid || expected_drive.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  always #1 clk_i = ~clk_i;

  // input driver
  always @(posedge clk_i) begin
    logic     v;
    in_item_t it;
    if (rst_ni && !(in_bus.valid && !in_bus.ready)) begin
      v = 1'b0;
      it = '0;
      if (in_bus.valid && in_bus.ready) begin
        it = pending_items.pop_front();
        if (it.operation == OP_START) begin
          plan_profile(it);
          n_start++;
        end else begin
          expected_drive.push_back(control_tick(it));
          n_tick++;
        end
        case ($urandom_range(0, 9))
          0, 1, 2: send_gap = $urandom_range(1, 3);
          3: send_gap = $urandom_range(10, 60);
          default: send_gap = 0;
        endcase
      end
      if (send_gap > 0) begin
        send_gap--;
      end else if (pending_items.size() != 0 && !hold_items) begin
        v = 1'b1;
        it = pending_items[0];
      end
      in_bus.valid <= v;
      if (v) begin
        in_bus.operation <= it.operation;
        in_bus.distance <= it.distance;
        in_bus.start_speed <= it.start_speed;
        in_bus.end_speed <= it.end_speed;
        in_bus.peak_speed <= it.peak_speed;
        in_bus.acceleration <= it.acceleration;
        in_bus.measured_speed <= it.measured_speed;
        in_bus.target_offset <= it.target_offset;
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_drive.size() == 0) begin
          $error("unexpected result drive=%0d motion_done=%0b",
                 out_bus.drive, out_bus.motion_done);
          fails++;
        end else begin
          want = expected_drive.pop_front();
          if (out_bus.drive !== want.drive) begin
            $error("drive: expected %0d actual %0d", want.drive, out_bus.drive);
            fails++;
          end
          if (out_bus.motion_done !== want.motion_done) begin
            $error("motion_done: expected %0b actual %0b", want.motion_done,
                   out_bus.motion_done);
            fails++;
          end
          if (want.motion_done) n_done++;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
        case ($urandom_range(0, 19))
          0, 1, 2: stall_left = $urandom_range(1, 3);
          3: stall_left = $urandom_range(10, 80);
          default: ;
        endcase
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int unsigned added, n;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_bus.valid = 1'b0;
    in_bus.operation = OP_TICK;
    in_bus.distance = '0;
    in_bus.start_speed = '0;
    in_bus.end_speed = '0;
    in_bus.peak_speed = '0;
    in_bus.acceleration = '0;
    in_bus.measured_speed = '0;
    in_bus.target_offset = '0;
    out_bus.ready = 1'b0;
    kp = GAIN_P_RST;
    ki = GAIN_I_RST;
    kd = GAIN_D_RST;
    speed_milli = 0;
    ramp_step = 0;
    heading = 0;
    accel_left = 0;
    cruise_left = 0;
    decel_left = 0;
    err_sum = 0;
    prev_err = 0;
    done_flag = 0;
    hold_items = 1'b0;
    send_gap = 0;
    stall_left = 0;
    quiet_cycles = 0;
    fails = 0;
    n_start = 0;
    n_tick = 0;
    n_done = 0;
    n_settings = 1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part with reset gains
    pending_items.push_back(mk_tick(0, 0));
    pending_items.push_back(mk_tick(-32768, 32767));
    pending_items.push_back(mk_tick(32767, -32768));
    pending_items.push_back(mk_start(0, 100, 50, 200, 1000));
    pending_items.push_back(mk_tick(5, 0));
    pending_items.push_back(mk_start(10, 0, 0, 10, 1000));
    repeat (4) pending_items.push_back(mk_tick(0, 0));
    pending_items.push_back(mk_start(-32768, 32767, 32767, 65535, 65535));
    pending_items.push_back(mk_tick(-32768, -32768));
    pending_items.push_back(mk_start(32767, 0, 0, 65535, 1));
    pending_items.push_back(mk_tick(32767, 32767));
    pending_items.push_back(mk_start(100, 10, 10, 100, 0));
    pending_items.push_back(mk_tick(0, 0));
    pending_items.push_back(mk_start(100, 10, 10, 0, 500));
    pending_items.push_back(mk_tick(0, 0));
    pending_items.push_back(mk_start(1, 200, 300, 100, 60000));
    pending_items.push_back(mk_tick(0, 0));
    pending_items.push_back(mk_start(3, 0, 0, 10, 65535));
    repeat (4) pending_items.push_back(mk_tick(0, 0));
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_gains(32'd0, 32'd0, 32'd0);
        1: set_gains(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        2: set_gains({16'hA5A5, GAIN_P_RST}, {16'h5A5A, GAIN_I_RST}, 32'h0001_0100);
        default: set_gains($urandom, $urandom, $urandom);
      endcase
      added = 0;
      while (added < 220) begin
        if ($urandom_range(0, 6) != 0) begin
          pending_items.push_back(random_start());
          n = $urandom_range(3, 40);
          repeat (n) pending_items.push_back(random_tick());
          added += n + 1;
        end else begin
          n = $urandom_range(1, 5);
          repeat (n) pending_items.push_back(
            $urandom_range(0, 1) ? random_tick() : random_start());
          added += n;
        end
      end
      drain();
    end

    if (expected_drive.size() != 0) begin
      $error("%0d results never arrived", expected_drive.size());
      fails++;
    end
    $display("covered %0d profile starts and %0d control ticks over %0d gain settings",
             n_start, n_tick, n_settings);
    $display("%0d tick results reported the motion as finished", n_done);
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/tvp_pkg.sv
rtl/tvp_if.sv
rtl/tvp_cfg.sv
rtl/tvp_div.sv
rtl/tvp_dp.sv
rtl/tvp_ctrl.sv
rtl/trapezoid_velocity_pi_loop.sv
tb/tb_top.sv
